[rtl/gbnp_pkg.sv]
// Shared constants, types and mask tables for the nine-pixel glyph blit.
package gbnp_pkg;

    localparam int CELL_ROWS  = 19;
    localparam int GLYPH_TOP  = 5;
    localparam int GLYPH_ROWS = 8;
    localparam int FONT_CHARS = 256;
    localparam int FONT_DEPTH = FONT_CHARS * GLYPH_ROWS;
    localparam int FONT_AW    = $clog2(FONT_DEPTH);
    localparam int IN_W       = 32;
    localparam int OUT_W      = 56;

    // Shifter request: one glyph row, the pixel phase and a blank-row flag.
    typedef struct packed {
        logic [7:0] glyph;
        logic [2:0] phase;
        logic       blank;
    } t_shift_req;

    typedef struct packed {
        logic [7:0] data_first;
        logic [7:0] data_second;
    } t_shift_rsp;

    function automatic logic [7:0] keep_first_f(input logic [2:0] phase);
        logic [7:0] k;
        case (phase)
            3'd0:    k = 8'h00;
            3'd1:    k = 8'hC0;
            3'd2:    k = 8'hE0;
            3'd3:    k = 8'hF0;
            3'd4:    k = 8'hF8;
            3'd5:    k = 8'hFC;
            3'd6:    k = 8'hFE;
            default: k = 8'hFF;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] keep_second_f(input logic [2:0] phase);
        logic [7:0] k;
        case (phase)
            3'd0:    k = 8'h3F;
            3'd1:    k = 8'h1F;
            3'd2:    k = 8'h0F;
            3'd3:    k = 8'h07;
            3'd4:    k = 8'h03;
            3'd5:    k = 8'h01;
            default: k = 8'h00;
        endcase
        return k;
    endfunction

endpackage

[rtl/gbnp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gbnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/gbnp_shift.sv]
// Shared funnel shifter placing one glyph row across two bitmap bytes.
module gbnp_shift (
    input  gbnp_pkg::t_shift_req i_req,
    output gbnp_pkg::t_shift_rsp o_rsp
);
    import gbnp_pkg::*;

    logic [3:0]  w_amount;
    logic [15:0] w_shifted;

    // 9-pixel cell: right shift by phase + 1, spill goes into the second byte
    assign w_amount  = {1'b0, i_req.phase} + 4'd1;
    assign w_shifted = {i_req.glyph, 8'h00} >> w_amount;

    always_comb begin
        if (i_req.blank) begin
            o_rsp = '0;
        end else begin
            o_rsp.data_first  = w_shifted[15:8];
            o_rsp.data_second = w_shifted[7:0];
        end
    end

endmodule

[rtl/glyph_blit_nine_pixel_cell.sv]
// Top level: font store, scan-row sequencer and output register of the glyph blit.
// A load transaction writes the font store; ready stays high.
// A draw transaction gives 19 results, one per cycle unless the output stalls; after accept
// each passes the sequencer registers and the output register. A new draw is taken only as
// the last row advances: the scan-row counter steps the one font store read port and the shared shifter once per row.
// Reset (synchronous, active low) clears the sequencer and output valid; font undefined.
module glyph_blit_nine_pixel_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // char_code[7:0], glyph_row[10:8], font_bits[18:11], text_line[23:19],
    // text_column[30:24], zero[31]
    input  logic [gbnp_pkg::IN_W-1:0]  i_s_axis_tdata,
    // func
    input  logic                       i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // line_out[4:0], scan_row[9:5], byte_index[16:10], keep_first[24:17],
    // data_first[32:25], keep_second[40:33], data_second[48:41], zero[55:49]
    output logic [gbnp_pkg::OUT_W-1:0] o_m_axis_tdata,
    output logic                       o_m_axis_tlast
);
    import gbnp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic       r_state, n_state;
    logic [4:0] r_row, n_row;
    logic [7:0] r_char, n_char;
    logic [4:0] r_line, n_line;
    logic [2:0] r_phase, n_phase;
    logic [6:0] r_byte, n_byte;
    logic       r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic       r_out_last;

    logic       w_accept;
    logic       w_adv;
    logic       w_last;
    logic [4:0] w_rel_row;
    logic [6:0] w_col;
    logic [FONT_AW-1:0] w_raddr;
    logic [FONT_AW-1:0] w_waddr;
    logic [7:0] w_glyph;
    t_shift_req w_req;
    t_shift_rsp w_rsp;

    assign w_adv    = (r_state == ST_RUN) && (!r_out_valid || i_m_axis_tready);
    assign w_last   = (r_row == 5'(CELL_ROWS - 1));
    assign o_s_axis_tready = (r_state == ST_IDLE) || (w_adv && w_last);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_col    = i_s_axis_tdata[30:24];

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_char      = r_char;
        n_line      = r_line;
        n_phase     = r_phase;
        n_byte      = r_byte;
        n_out_valid = r_out_valid;
        if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_adv) begin
            n_out_valid = 1'b1;
            if (w_last) begin
                n_row   = '0;
                n_state = ST_IDLE;
            end else begin
                n_row = r_row + 5'd1;
            end
        end
        if (w_accept && i_s_axis_tuser) begin
            n_state = ST_RUN;
            n_row   = '0;
            n_char  = i_s_axis_tdata[7:0];
            n_line  = i_s_axis_tdata[23:19];
            n_phase = w_col[2:0];
            // column*9/8 == column + column/8
            n_byte  = w_col + {3'd0, w_col[6:3]};
        end
    end

    // Read address follows the next row so the registered data lines up with r_row
    assign w_rel_row = n_row - 5'(GLYPH_TOP);
    assign w_raddr   = {n_char, w_rel_row[2:0]};
    assign w_waddr   = {i_s_axis_tdata[7:0], i_s_axis_tdata[10:8]};

    gbnp_ram #(
        .WIDTH(8),
        .DEPTH(FONT_DEPTH)
    ) u_font (
        .i_clk  (i_clk),
        .i_we   (w_accept && !i_s_axis_tuser),
        .i_waddr(w_waddr),
        .i_wdata(i_s_axis_tdata[18:11]),
        .i_raddr(w_raddr),
        .o_rdata(w_glyph)
    );

    assign w_req.glyph = w_glyph;
    assign w_req.phase = r_phase;
    assign w_req.blank = (r_row < 5'(GLYPH_TOP)) || (r_row >= 5'(GLYPH_TOP + GLYPH_ROWS));

    gbnp_shift u_shift (
        .i_req(w_req),
        .o_rsp(w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_line  <= n_line;
        r_phase <= n_phase;
        r_byte  <= n_byte;
        if (w_adv) begin
            r_out_data <= {7'd0, w_rsp.data_second, keep_second_f(r_phase),
                           w_rsp.data_first, keep_first_f(r_phase),
                           r_byte, r_row, r_line};
            r_out_last <= w_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

[rtl/gbnp_check.sv]
// Port-level checker for the glyph blit, bound to the top level.
module gbnp_check (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_axis_tvalid,
    input logic                       o_s_axis_tready,
    input logic                       i_s_axis_tuser,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready,
    input logic [gbnp_pkg::OUT_W-1:0] o_m_axis_tdata,
    input logic                       o_m_axis_tlast
);
    import gbnp_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // a draw transaction blocks the input for its scan rows
    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser |=> !o_s_axis_tready)
        else $error("input ready straight after a draw");

    // a font load leaves the block free
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser |=> o_s_axis_tready)
        else $error("input not ready after a load");

    // tlast marks exactly the final scan row
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tdata[9:5] == 5'(CELL_ROWS - 1))))
        else $error("tlast does not match scan row");

endmodule

bind glyph_blit_nine_pixel_cell gbnp_check u_check (.*);
